// ----- design/u8dec_pkg.sv -----
`default_nettype none

package u8dec_pkg;

  localparam int unsigned MidQueueDepth = 2;
  localparam int unsigned OutQueueDepth = 2;

  // Byte classes as seen by the front end
  typedef enum logic [2:0] {
    CLS_ASCII = 3'd0,  // 0xxxxxxx
    CLS_CONT  = 3'd1,  // 10xxxxxx
    CLS_LEAD2 = 3'd2,  // 110xxxxx
    CLS_LEAD3 = 3'd3,  // 1110xxxx
    CLS_BAD   = 3'd4   // 1111xxxx
  } u8dec_cls_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_CONT  = 2'd1,
    ERR_TRUNC = 2'd2,
    ERR_LEAD  = 2'd3
  } u8dec_err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_end;
    u8dec_cls_e cls;
  } u8dec_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    u8dec_err_e  error_kind;
    logic        last_of_string;
  } u8dec_res_t;

endpackage

`default_nettype wire

// ----- design/u8dec_fifo.sv -----
`default_nettype none

module u8dec_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [Width-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/u8dec_front.sv -----
`default_nettype none

module u8dec_front (
  input  wire logic               push_i,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               string_end_i,
  input  wire logic               mid_full_i,
  output logic                    mid_push_o,
  output u8dec_pkg::u8dec_item_t  mid_item_o
);

  import u8dec_pkg::*;

  u8dec_cls_e cls;

  // Classify on the top bits of the byte
  always_comb begin
    if (data_byte_i inside {[8'h00:8'h7F]}) begin
      cls = CLS_ASCII;
    end else if (data_byte_i inside {[8'h80:8'hBF]}) begin
      cls = CLS_CONT;
    end else if (data_byte_i inside {[8'hC0:8'hDF]}) begin
      cls = CLS_LEAD2;
    end else if (data_byte_i inside {[8'hE0:8'hEF]}) begin
      cls = CLS_LEAD3;
    end else begin
      cls = CLS_BAD;
    end
  end

  assign mid_push_o            = push_i && !mid_full_i;
  assign mid_item_o.data_byte  = data_byte_i;
  assign mid_item_o.string_end = string_end_i;
  assign mid_item_o.cls        = cls;

endmodule

`default_nettype wire

// ----- design/u8dec_back.sv -----
`default_nettype none

module u8dec_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   mid_empty_i,
  input  wire u8dec_pkg::u8dec_item_t mid_item_i,
  output logic                        mid_pop_o,
  input  wire logic                   res_full_i,
  output logic                        res_push_o,
  output u8dec_pkg::u8dec_res_t       res_o
);

  import u8dec_pkg::*;

  logic [1:0] pend_q, pend_d;
  logic [9:0] part_q, part_d;
  logic       disc_q, disc_d;
  logic       emit;
  logic       last;
  logic [7:0] b;

  assign b         = mid_item_i.data_byte;
  assign last      = mid_item_i.string_end;
  assign mid_pop_o = !mid_empty_i && !res_full_i;

  always_comb begin
    pend_d = pend_q;
    part_d = part_q;
    disc_d = disc_q;
    emit   = 1'b0;
    res_o.code_unit      = '0;
    res_o.error_kind     = ERR_NONE;
    res_o.last_of_string = last;

    if (mid_pop_o) begin
      if (disc_q) begin
        if (last) begin
          disc_d = 1'b0;
        end
      end else if (pend_q == 2'd0) begin
        case (mid_item_i.cls)
          CLS_ASCII: begin
            emit = 1'b1;
            res_o.code_unit = {8'h00, b};
          end
          CLS_LEAD2: begin
            if (last) begin
              emit = 1'b1;
              res_o.error_kind = ERR_TRUNC;
            end else begin
              part_d = {5'd0, b[4:0]};
              pend_d = 2'd1;
            end
          end
          CLS_LEAD3: begin
            if (last) begin
              emit = 1'b1;
              res_o.error_kind = ERR_TRUNC;
            end else begin
              part_d = {6'd0, b[3:0]};
              pend_d = 2'd2;
            end
          end
          default: begin
            emit = 1'b1;
            res_o.error_kind = ERR_LEAD;
          end
        endcase
      end else if (mid_item_i.cls != CLS_CONT) begin
        emit = 1'b1;
        res_o.error_kind = ERR_CONT;
      end else if (pend_q == 2'd1) begin
        emit = 1'b1;
        res_o.code_unit = {part_q, b[5:0]};
        pend_d = 2'd0;
        part_d = '0;
      end else if (last) begin
        emit = 1'b1;
        res_o.error_kind = ERR_TRUNC;
      end else begin
        part_d = {part_q[3:0], b[5:0]};
        pend_d = 2'd1;
      end

      // Any error: drop state, discard the rest unless this was the last byte
      if (emit && (res_o.error_kind != ERR_NONE)) begin
        pend_d = 2'd0;
        part_d = '0;
        disc_d = !last;
      end
    end
  end

  assign res_push_o = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
      part_q <= '0;
      disc_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      part_q <= part_d;
      disc_q <= disc_d;
    end
  end

`ifndef SYNTH
  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("pending count reached three");

  a_disc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (pend_q == 2'd0))
    else $error("discarding with a sequence in progress");

  a_err_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && (res_o.error_kind != ERR_NONE) && !last) |=> disc_q)
    else $error("error mid-string did not start discarding");

  a_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> (mid_pop_o && !disc_q))
    else $error("result without a consumed byte");
`endif

endmodule

`default_nettype wire

// ----- design/utf8_to_ucs2_decoder_top.sv -----
`default_nettype none

// Channel  | Direction | Handshake         | Payload
// ---------+-----------+-------------------+----------------------------------------
// bytes    | in        | push / full       | data_byte_i[7:0], string_end_i
// results  | out       | pop / empty       | code_unit_o[15:0], error_kind_o[1:0],
//          |           |                   | last_of_string_o
//
// One byte is taken per cycle while full is low; the back end decodes one queued
// byte per cycle while the mid queue holds one and the result queue has room.
// A decoded byte that yields a result writes it into the result queue, and empty
// then falls. Bytes that produce no result leave nothing behind.
// Reset (rst_ni low, asynchronous) empties both queues and clears the decoder.
// While the result queue is full the back end holds; the mid queue then fills
// and full rises, so a stalled reader throttles the writer without loss.

module utf8_to_ucs2_decoder_top #(
  parameter int unsigned MidDepth = u8dec_pkg::MidQueueDepth,
  parameter int unsigned OutDepth = u8dec_pkg::OutQueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        string_end_i,
  input  wire logic        pop,
  output logic             empty,
  output logic      [15:0] code_unit_o,
  output logic      [1:0]  error_kind_o,
  output logic             last_of_string_o
);

  import u8dec_pkg::*;

  localparam int unsigned ItemW = $bits(u8dec_item_t);
  localparam int unsigned ResW  = $bits(u8dec_res_t);

  u8dec_item_t      front_item;
  logic             front_push;
  logic             mid_full;
  logic             mid_empty;
  logic             mid_pop;
  logic [ItemW-1:0] mid_rdata;
  u8dec_item_t      mid_item;

  u8dec_res_t       back_res;
  logic             res_push;
  logic             res_full;
  logic [ResW-1:0]  out_rdata;
  u8dec_res_t       out_res;

  assign full = mid_full;

  // Front end: classify each byte on the way into the mid queue
  u8dec_front u_front (
    .push_i       (push),
    .data_byte_i  (data_byte_i),
    .string_end_i (string_end_i),
    .mid_full_i   (mid_full),
    .mid_push_o   (front_push),
    .mid_item_o   (front_item)
  );

  // Mid queue decouples acceptance from decoding
  u8dec_fifo #(
    .Width (ItemW),
    .Depth (MidDepth)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .wdata_i (front_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty)
  );

  assign mid_item = u8dec_item_t'(mid_rdata);

  // Back end: sequence tracking, assembly and error handling
  u8dec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_item),
    .mid_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // Result queue: holds finished results until the reader pops them
  u8dec_fifo #(
    .Width (ResW),
    .Depth (OutDepth)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .empty_o (empty)
  );

  assign out_res          = u8dec_res_t'(out_rdata);
  assign code_unit_o      = out_res.code_unit;
  assign error_kind_o     = out_res.error_kind;
  assign last_of_string_o = out_res.last_of_string;

endmodule

`default_nettype wire
